// ----- rtl/esuc_pkg.sv -----
// Shared constants, types and the cosine table builder for the swing-up controller.
package esuc_pkg;

  localparam int COS_TABLE_BITS_DEF = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_MASS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CATCH_ANGLE = 3'd4;

  localparam logic [15:0] GRAVITY_RST     = 16'd2510;
  localparam logic [15:0] POLE_MASS_RST   = 16'd4915;
  localparam logic [15:0] POLE_LENGTH_RST = 16'd9699;
  localparam logic [14:0] DRIVE_LIMIT_RST = 15'd4096;
  localparam logic [14:0] CATCH_ANGLE_RST = 15'd2867;

  // pi in Q4.12 and the rad-to-turn scale in Q0.44 per Q4.12 LSB
  localparam logic signed [16:0] PI_Q12     = 17'sd12868;
  localparam logic [29:0]        TURN_SCALE = 30'd683565276;
  localparam logic signed [16:0] ONE_Q14    = 17'sd16384;

  typedef struct packed {
    logic [15:0] gravity;
    logic [15:0] pole_mass;
    logic [15:0] pole_length;
    logic [14:0] drive_limit;
    logic [14:0] catch_angle;
  } cfg_t;

  // Cosine of z/65536 of a quarter turn, Q14, evaluated at elaboration only.
  function automatic logic [14:0] cos_quarter_q14(input logic [16:0] z);
    logic [63:0]        theta;
    logic [63:0]        x2;
    logic [63:0]        h;
    logic signed [63:0] c;
    theta = 64'(z) * 64'd25736;
    x2    = (theta * theta) >> 30;
    h     = 64'd1073741824 - x2 / 64'd90;
    h     = 64'd1073741824 - ((x2 * h) >> 30) / 64'd56;
    h     = 64'd1073741824 - ((x2 * h) >> 30) / 64'd30;
    h     = 64'd1073741824 - ((x2 * h) >> 30) / 64'd12;
    c     = signed'(64'd1073741824 - ((x2 * h) >> 30) / 64'd2);
    if (c < 0) begin
      c = 64'sd0;
    end
    return 15'((64'(c) + 64'd32768) >> 16);
  endfunction

endpackage

// ----- rtl/esuc_in_if.sv -----
// Sample channel: pole angle, pole rate and regulator drive.
interface esuc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pole_angle;
  logic signed [15:0] pole_rate;
  logic signed [15:0] regulator_drive;

  modport source (output valid, pole_angle, pole_rate, regulator_drive, input ready);
  modport sink   (input valid, pole_angle, pole_rate, regulator_drive, output ready);
endinterface

// ----- rtl/esuc_out_if.sv -----
// Command channel: actuator drive and swing-up flag.
interface esuc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic               swinging;

  modport source (output valid, drive, swinging, input ready);
  modport sink   (input valid, drive, swinging, output ready);
endinterface

// ----- rtl/esuc_cfg_regs.sv -----
// Configuration register file with reset values and index decode.
module esuc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [esuc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [esuc_pkg::CFG_DATA_W-1:0] wr_data,
  output esuc_pkg::cfg_t                 cfg
);
  import esuc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity     <= GRAVITY_RST;
      cfg.pole_mass   <= POLE_MASS_RST;
      cfg.pole_length <= POLE_LENGTH_RST;
      cfg.drive_limit <= DRIVE_LIMIT_RST;
      cfg.catch_angle <= CATCH_ANGLE_RST;
    end else if (wr_en) begin
      // indexes past the list are dropped
      unique case (wr_index)
        REG_GRAVITY:     cfg.gravity     <= wr_data;
        REG_POLE_MASS:   cfg.pole_mass   <= wr_data;
        REG_POLE_LENGTH: cfg.pole_length <= wr_data;
        REG_DRIVE_LIMIT: cfg.drive_limit <= wr_data[14:0];
        REG_CATCH_ANGLE: cfg.catch_angle <= wr_data[14:0];
        default: ;
      endcase
    end
  end
endmodule

// ----- rtl/esuc_cos_rom.sv -----
// Quarter-wave cosine table, Q14 magnitude, registered read.
module esuc_cos_rom #(
  parameter int TABLE_BITS = esuc_pkg::COS_TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [TABLE_BITS-2:0] addr,
  output logic [14:0]           cos_mag
);
  import esuc_pkg::*;

  localparam int QUARTER = 1 << (TABLE_BITS - 2);
  localparam int ZSHIFT  = 18 - TABLE_BITS;

  logic [14:0] rom [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    assign rom[k] = cos_quarter_q14(17'(k << ZSHIFT));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_mag <= rom[addr];
    end
  end
endmodule

// ----- rtl/energy_swing_up_controller.sv -----
// Top level: five-stage swing-up / catch selector pipeline.
//
//   channel   dir  handshake            payload
//   sample    in   valid/ready          pole_angle, pole_rate, regulator_drive
//   command   out  valid/ready          drive, swinging
//   config    in   wr_en (no wait)      wr_index, wr_data
//
// Each sample passes the five register stages in order (products, table index and
// products, table read and kinetic product, potential product, energy sign and
// drive select), each with its own valid bit, so one sample enters per cycle while
// the command output is not held.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// fill while the command output is held.
// Synchronous reset clears all stage valid bits and loads register reset values.
module energy_swing_up_controller #(
  parameter int COS_TABLE_BITS = esuc_pkg::COS_TABLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  esuc_in_if.sink                        sample,
  esuc_out_if.source                     command,
  input  logic                           wr_en,
  input  logic [esuc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [esuc_pkg::CFG_DATA_W-1:0] wr_data
);
  import esuc_pkg::*;

  localparam int          B          = COS_TABLE_BITS;
  localparam int          AW         = B - 1;
  localparam logic [43:0] PHASE_HALF = 44'(64'd1 << (43 - B));
  localparam logic [AW-1:0] QUARTER  = AW'(64'd1 << (B - 2));

  cfg_t cfg;

  esuc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // stage valids and advance enables
  logic s1_v, s2_v, s3_v, s4_v;
  logic en1, en2, en3, en4, en5;

  assign en5 = !command.valid || command.ready;
  assign en4 = !s4_v || en5;
  assign en3 = !s3_v || en4;
  assign en2 = !s2_v || en3;
  assign en1 = !s1_v || en2;
  assign sample.ready = en1;

  // ---------------- stage 1: offset, catch test, products
  logic signed [16:0] off;
  logic [16:0]        mag;
  logic [46:0]        phase_prod;
  logic signed [31:0] rate_sq;

  always_comb begin
    off        = 17'(sample.pole_angle) - PI_Q12;
    mag        = off[16] ? 17'(-off) : 17'(off);
    phase_prod = 47'(off) * 47'(TURN_SCALE);
    rate_sq    = 32'(sample.pole_rate) * 32'(sample.pole_rate);
  end

  logic               s1_catch, s1_rate_neg, s1_rate_zero;
  logic signed [15:0] s1_reg;
  logic [43:0]        s1_phase;
  logic [31:0]        s1_ml;
  logic [30:0]        s1_w2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en1) begin
      s1_v <= sample.valid;
    end
    if (en1) begin
      s1_catch     <= mag < {2'b00, cfg.catch_angle};
      s1_rate_neg  <= sample.pole_rate[15];
      s1_rate_zero <= sample.pole_rate == 16'sd0;
      s1_reg       <= sample.regulator_drive;
      s1_phase     <= phase_prod[43:0];
      s1_ml        <= 32'(cfg.pole_mass) * 32'(cfg.pole_length);
      s1_w2        <= rate_sq[30:0];
    end
  end

  // ---------------- stage 2: table index, m*l^2, m*g*l
  logic [43:0]   phase_sum;
  logic [B-1:0]  idx;
  logic [AW-1:0] r_ext;
  logic [47:0]   ml2_prod, mgl_prod;

  always_comb begin
    phase_sum = s1_phase + PHASE_HALF;
    idx       = phase_sum[43 -: B];
    r_ext     = AW'(idx[B-3:0]);
    ml2_prod  = 48'(s1_ml) * 48'(cfg.pole_length);
    mgl_prod  = 48'(s1_ml) * 48'(cfg.gravity);
  end

  logic               s2_catch, s2_rate_neg, s2_rate_zero, s2_cneg;
  logic signed [15:0] s2_reg;
  logic [AW-1:0]      s2_addr;
  logic [31:0]        s2_ml2, s2_mgl;
  logic [30:0]        s2_w2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en2) begin
      s2_v <= s1_v;
    end
    if (en2) begin
      s2_catch     <= s1_catch;
      s2_rate_neg  <= s1_rate_neg;
      s2_rate_zero <= s1_rate_zero;
      s2_reg       <= s1_reg;
      // odd quadrants mirror the quarter wave, middle two negate it
      s2_addr      <= idx[B-2] ? QUARTER - r_ext : r_ext;
      s2_cneg      <= idx[B-1] ^ idx[B-2];
      s2_ml2       <= ml2_prod[47:16];
      s2_mgl       <= mgl_prod[47:16];
      s2_w2        <= s1_w2;
    end
  end

  // ---------------- stage 3: cosine lookup, kinetic term
  logic [14:0] cos_mag;
  logic [62:0] kin_prod;

  esuc_cos_rom #(.TABLE_BITS(B)) u_cos (
    .clk     (clk),
    .en      (en3),
    .addr    (s2_addr),
    .cos_mag (cos_mag)
  );

  assign kin_prod = 63'(s2_ml2) * 63'(s2_w2);

  logic               s3_catch, s3_rate_neg, s3_rate_zero, s3_cneg;
  logic signed [15:0] s3_reg;
  logic [47:0]        s3_kin;
  logic [31:0]        s3_mgl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en3) begin
      s3_v <= s2_v;
    end
    if (en3) begin
      s3_catch     <= s2_catch;
      s3_rate_neg  <= s2_rate_neg;
      s3_rate_zero <= s2_rate_zero;
      s3_cneg      <= s2_cneg;
      s3_reg       <= s2_reg;
      s3_kin       <= kin_prod[62:15];
      s3_mgl       <= s2_mgl;
    end
  end

  // ---------------- stage 4: potential term
  logic signed [16:0] cos_s, cos_m1;
  logic signed [49:0] pot_prod;

  always_comb begin
    cos_s    = s3_cneg ? -17'(cos_mag) : 17'(cos_mag);
    cos_m1   = cos_s - ONE_Q14;
    pot_prod = 50'(signed'({1'b0, s3_mgl})) * 50'(cos_m1);
  end

  logic               s4_catch, s4_rate_neg, s4_rate_zero, s4_c_neg, s4_c_zero;
  logic signed [15:0] s4_reg;
  logic [47:0]        s4_kin;
  logic signed [49:0] s4_pot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en4) begin
      s4_v <= s3_v;
    end
    if (en4) begin
      s4_catch     <= s3_catch;
      s4_rate_neg  <= s3_rate_neg;
      s4_rate_zero <= s3_rate_zero;
      s4_c_zero    <= cos_mag == 15'd0;
      s4_c_neg     <= s3_cneg && (cos_mag != 15'd0);
      s4_reg       <= s3_reg;
      s4_kin       <= s3_kin;
      s4_pot       <= pot_prod;
    end
  end

  // ---------------- stage 5: energy error sign, drive select
  logic signed [49:0] d_err;
  logic               push_neg;
  logic signed [15:0] drive_next;

  always_comb begin
    d_err    = signed'({2'b00, s4_kin}) + s4_pot;
    push_neg = (d_err != 50'sd0) && !s4_rate_zero && !s4_c_zero &&
               !(d_err[49] ^ s4_rate_neg ^ s4_c_neg);
    priority if (s4_catch) begin
      drive_next = s4_reg;
    end else if (push_neg) begin
      drive_next = 16'sd0 - signed'({1'b0, cfg.drive_limit});
    end else begin
      drive_next = signed'({1'b0, cfg.drive_limit});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command.valid <= 1'b0;
    end else if (en5) begin
      command.valid <= s4_v;
    end
    if (en5) begin
      command.drive    <= drive_next;
      command.swinging <= !s4_catch;
    end
  end

  // ---------------- checks
  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (s1_v && s2_v && s3_v && s4_v && command.valid && !command.ready))
    else $error("sample request refused with room in the pipeline");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_v && !en2 |=> s1_v && $stable(s1_phase))
    else $error("stage 1 request lost while stalled");

  a_s4_hold: assert property (@(posedge clk) disable iff (rst)
    s4_v && !en5 |=> s4_v && $stable(s4_pot))
    else $error("stage 4 request lost while stalled");

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    s3_v |-> cos_mag <= 15'd16384)
    else $error("cosine magnitude above one");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !command.valid)
    else $error("command valid right after reset");
endmodule

// ----- test/energy_swing_up_controller_test.sv -----
// Self-checking swing-up controller bench: directed samples, then random traffic under several register settings.
`timescale 1ns / 1ps

typedef longint unsigned u64_t;

typedef struct packed {
  logic signed [15:0] drive;
  logic               swinging;
} command_t;

class swing_scoreboard;
  localparam int   LUT_BITS = esuc_pkg::COS_TABLE_BITS_DEF;
  localparam u64_t UNIT_Q30 = u64_t'(1) << 30;

  logic [15:0] gravity;
  logic [15:0] pole_mass;
  logic [15:0] pole_length;
  logic [14:0] drive_limit;
  logic [14:0] catch_angle;
  command_t    command_q[$];
  int          failures;

  function new();
    gravity     = esuc_pkg::GRAVITY_RST;
    pole_mass   = esuc_pkg::POLE_MASS_RST;
    pole_length = esuc_pkg::POLE_LENGTH_RST;
    drive_limit = esuc_pkg::DRIVE_LIMIT_RST;
    catch_angle = esuc_pkg::CATCH_ANGLE_RST;
    failures    = 0;
  endfunction

  function void write_reg(logic [esuc_pkg::CFG_IDX_W-1:0] index, logic [15:0] value);
    case (index)
      esuc_pkg::REG_GRAVITY:     gravity = value;
      esuc_pkg::REG_POLE_MASS:   pole_mass = value;
      esuc_pkg::REG_POLE_LENGTH: pole_length = value;
      esuc_pkg::REG_DRIVE_LIMIT: drive_limit = value[14:0];
      esuc_pkg::REG_CATCH_ANGLE: catch_angle = value[14:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return command_q.size();
  endfunction

  // Q14 cosine over one quarter turn, z is Q0.16 of the quarter
  function longint quarter_cos(u64_t z);
    u64_t   theta;
    u64_t   x2;
    u64_t   h;
    longint c;
    theta = z * 64'd25736;
    x2    = (theta * theta) >> 30;
    h     = UNIT_Q30 - x2 / 64'd90;
    h     = UNIT_Q30 - ((x2 * h) >> 30) / 64'd56;
    h     = UNIT_Q30 - ((x2 * h) >> 30) / 64'd30;
    h     = UNIT_Q30 - ((x2 * h) >> 30) / 64'd12;
    c     = longint'(UNIT_Q30) - longint'(((x2 * h) >> 30) / 64'd2);
    if (c < 0) begin
      c = 0;
    end
    return longint'((u64_t'(c) + 64'd32768) >> 16);
  endfunction

  // Q2.14 cosine of a Q4.12 offset, phase rounded to the lookup resolution
  function longint offset_cos(int off);
    u64_t phase;
    u64_t idx;
    u64_t quarter;
    u64_t r;
    u64_t zr;
    u64_t zc;
    int   q;
    quarter = u64_t'(1) << (LUT_BITS - 2);
    phase   = (u64_t'(longint'(off)) * u64_t'(esuc_pkg::TURN_SCALE)) & ((u64_t'(1) << 44) - 1);
    idx     = ((phase + (u64_t'(1) << (43 - LUT_BITS))) >> (44 - LUT_BITS))
              & ((u64_t'(1) << LUT_BITS) - 1);
    q       = int'(idx >> (LUT_BITS - 2));
    r       = idx & (quarter - 1);
    zr      = r << (18 - LUT_BITS);
    zc      = (quarter - r) << (18 - LUT_BITS);
    case (q)
      0:       return quarter_cos(zr);
      1:       return -quarter_cos(zc);
      2:       return -quarter_cos(zr);
      default: return quarter_cos(zc);
    endcase
  endfunction

  function void note_sample(logic signed [15:0] angle, logic signed [15:0] rate,
                            logic signed [15:0] reg_drive);
    int       off;
    int       mag;
    int       negs;
    longint   cosv;
    longint   kinetic;
    longint   potential;
    longint   energy;
    u64_t     ml;
    u64_t     ml2;
    u64_t     w2;
    u64_t     mgl;
    command_t want;
    off = int'(angle) - int'(esuc_pkg::PI_Q12);
    mag = (off < 0) ? -off : off;
    if (mag < int'(catch_angle)) begin
      want.drive    = reg_drive;
      want.swinging = 1'b0;
    end else begin
      cosv      = offset_cos(off);
      ml        = u64_t'(pole_mass) * u64_t'(pole_length);
      ml2       = (ml * u64_t'(pole_length)) >> 16;
      w2        = u64_t'(longint'(rate) * longint'(rate));
      kinetic   = longint'((ml2 * w2) >> 15);
      mgl       = (ml * u64_t'(gravity)) >> 16;
      potential = longint'(mgl) * (cosv - longint'(esuc_pkg::ONE_Q14));
      energy    = kinetic + potential;
      want.swinging = 1'b1;
      want.drive    = {1'b0, drive_limit};
      // drive negative only when energy error, rate and cosine are nonzero and their sign product is positive
      if (energy != 0 && rate != 0 && cosv != 0) begin
        negs = int'(energy < 0) + int'(rate < 0) + int'(cosv < 0);
        if (negs % 2 == 0) begin
          want.drive = 16'd0 - {1'b0, drive_limit};
        end
      end
    end
    command_q.push_back(want);
  endfunction

  function void check_command(logic signed [15:0] drive, logic swinging);
    command_t want;
    if (command_q.size() == 0) begin
      failures++;
      if (failures <= 10) begin
        $display("unexpected command: drive %0d swinging %0b", drive, swinging);
      end
      return;
    end
    want = command_q.pop_front();
    if (drive !== want.drive || swinging !== want.swinging) begin
      failures++;
      if (failures <= 10) begin
        $display("command mismatch: drive exp %0d got %0d, swinging exp %0b got %0b",
                 want.drive, drive, want.swinging, swinging);
      end
    end
  endfunction
endclass

module energy_swing_up_controller_test;
  import esuc_pkg::*;

  localparam int LUT_BITS          = COS_TABLE_BITS_DEF;
  localparam int IDLE_LIMIT        = 2000;
  localparam int SETTLE_CYCLES     = 8;
  localparam int SETTINGS_COUNT    = 8;
  localparam int ITEMS_PER_SETTING = 216;
  localparam int UPRIGHT           = 12868;
  localparam int QUARTER_TURN      = 6434;

  // indexes past the register list, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  esuc_in_if  sample();
  esuc_out_if command();

  energy_swing_up_controller #(.COS_TABLE_BITS(LUT_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .command  (command),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  swing_scoreboard sb;
  bit              steady;
  int              hold_left;
  int              idle_cycles = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // command side: check each accepted command, then stall at random unless steady
  always @(posedge clk) begin
    if (!rst && command.valid && command.ready) begin
      sb.check_command(command.drive, command.swinging);
    end
    if (steady) begin
      command.ready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      command.ready <= 1'b0;
    end else begin
      hold_left = pick_gap();
      command.ready <= (hold_left == 0);
      if (hold_left > 0) hold_left--;
    end
  end

  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (command.valid && command.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic signed [15:0] angle, input logic signed [15:0] rate,
                             input logic signed [15:0] reg_drive);
    int gap;
    sample.valid           <= 1'b1;
    sample.pole_angle      <= angle;
    sample.pole_rate       <= rate;
    sample.regulator_drive <= reg_drive;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    sb.note_sample(angle, rate, reg_drive);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int          r;
    logic [15:0] angle;
    logic [15:0] rate;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      angle = 16'(UPRIGHT + int'($urandom_range(0, 8000)) - 4000);
    end else begin
      angle = 16'($urandom);
    end
    r = $urandom_range(0, 9);
    if (r < 2) begin
      rate = 16'(int'($urandom_range(0, 2048)) - 1024);
    end else if (r < 3) begin
      rate = 16'(int'($urandom_range(0, 2)) - 1);
    end else begin
      rate = 16'($urandom);
    end
    send_sample(angle, rate, 16'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [15:0] value);
    wr_en    <= 1'b1;
    wr_index <= index;
    wr_data  <= value;
    @(posedge clk);
    sb.write_reg(index, value);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every command is back and the pipeline is empty
  task automatic settle();
    sample.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input int p);
    case (p)
      0: begin
        write_reg(REG_GRAVITY, 16'hFFFF);
        write_reg(REG_POLE_MASS, 16'hFFFF);
        write_reg(REG_POLE_LENGTH, 16'hFFFF);
        write_reg(REG_DRIVE_LIMIT, 16'hFFFF);
        write_reg(REG_CATCH_ANGLE, 16'h0000);
        write_reg(REG_SPARE_LO, 16'($urandom));
      end
      1: begin
        write_reg(REG_GRAVITY, 16'h0000);
        write_reg(REG_POLE_MASS, 16'h0000);
        write_reg(REG_POLE_LENGTH, 16'h0000);
        write_reg(REG_DRIVE_LIMIT, 16'h0000);
        write_reg(REG_CATCH_ANGLE, 16'h7FFF);
      end
      SETTINGS_COUNT - 1: begin
        write_reg(REG_GRAVITY, GRAVITY_RST);
        write_reg(REG_POLE_MASS, POLE_MASS_RST);
        write_reg(REG_POLE_LENGTH, POLE_LENGTH_RST);
        write_reg(REG_DRIVE_LIMIT, {1'b0, DRIVE_LIMIT_RST});
        write_reg(REG_CATCH_ANGLE, {1'b0, CATCH_ANGLE_RST});
      end
      default: begin
        write_reg(REG_GRAVITY, (p == 2) ? 16'h0000 : 16'($urandom));
        write_reg(REG_POLE_MASS, (p == 3) ? 16'h0000 : 16'($urandom));
        write_reg(REG_POLE_LENGTH, (p == 4) ? 16'h0000 : 16'($urandom));
        write_reg(REG_DRIVE_LIMIT, 16'($urandom));
        write_reg(REG_CATCH_ANGLE, {1'($urandom), 15'($urandom_range(0, 6000))});
        write_reg(REG_SPARE_HI, 16'($urandom));
      end
    endcase
  endtask

  initial begin
    sb                     = new();
    steady                 = 1'b0;
    hold_left              = 0;
    rst                    = 1'b1;
    wr_en                  = 1'b0;
    wr_index               = '0;
    wr_data                = '0;
    sample.valid           = 1'b0;
    sample.pole_angle      = '0;
    sample.pole_rate       = '0;
    sample.regulator_drive = '0;
    command.ready          = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // catch boundary, field extremes, hanging and horizontal poses, angles past a turn
    send_sample(16'(UPRIGHT), 16'sd0, 16'sd32767);
    send_sample(16'(UPRIGHT + 2866), 16'sd100, -16'sd32768);
    send_sample(16'(UPRIGHT + 2867), 16'sd5000, 16'sd1);
    send_sample(16'(UPRIGHT - 2866), 16'sd0, 16'sd12345);
    send_sample(16'(UPRIGHT - 2867), -16'sd5000, -16'sd1);
    send_sample(-16'sd32768, 16'sd32767, 16'sd0);
    send_sample(-16'sd32768, -16'sd32768, 16'sd0);
    send_sample(16'sd32767, 16'sd32767, -16'sd32768);
    send_sample(16'sd32767, -16'sd32768, 16'sd32767);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd20000, 16'sd0);
    send_sample(16'sd0, -16'sd20000, 16'sd0);
    send_sample(16'sd0, 16'sd1024, 16'sd0);
    send_sample(16'sd0, -16'sd1024, 16'sd0);
    send_sample(16'(UPRIGHT + QUARTER_TURN), 16'sd3000, 16'sd0);
    send_sample(16'(UPRIGHT - QUARTER_TURN), -16'sd3000, 16'sd0);
    send_sample(16'(UPRIGHT + 8000), 16'sd2048, 16'sd0);
    send_sample(16'(UPRIGHT - 8000), -16'sd2048, 16'sd0);
    send_sample(16'(UPRIGHT + 8000), 16'sd30000, 16'sd0);
    send_sample(16'(2 * UPRIGHT), 16'sd500, 16'sd0);
    send_sample(16'(-UPRIGHT), 16'sd700, 16'sd0);
    send_sample(16'(-UPRIGHT - QUARTER_TURN), 16'sd1, 16'sd0);

    for (int p = 0; p < SETTINGS_COUNT; p++) begin
      settle();
      apply_setting(p);
      steady = (p % 3 == 1);
      repeat (ITEMS_PER_SETTING) send_random();
    end
    settle();

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ----- energy_swing_up_controller.f -----
rtl/esuc_pkg.sv
rtl/esuc_in_if.sv
rtl/esuc_out_if.sv
rtl/esuc_cfg_regs.sv
rtl/esuc_cos_rom.sv
rtl/energy_swing_up_controller.sv
test/energy_swing_up_controller_test.sv
